[src/msd_pkg.sv]
package msd_pkg;

    localparam int NUM_W = 24;
    localparam int TYPE_W = 8;
    localparam int CNT_W = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [NUM_W-1:0] HALF_RANGE = 24'h800000;
    localparam logic [CNT_W-1:0] CNT_MAX = 8'hff;

    // Reset values of the configuration registers.
    localparam logic [TYPE_W-1:0] TERM_TYPE_RST = 8'd0;
    localparam logic [CNT_W-1:0] RETRY_LIMIT_RST = 8'd100;
    localparam logic [NUM_W-1:0] INIT_NUMBER_RST = 24'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_TYPE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_NUMBER = 2'd2;

    // Message, event and error codes.
    localparam logic [1:0] SEND_NONE = 2'd0;
    localparam logic [1:0] SEND_REQ = 2'd1;
    localparam logic [1:0] SEND_ACK = 2'd2;
    localparam logic [1:0] SEND_REJ = 2'd3;

    localparam logic [1:0] EVT_NONE = 2'd0;
    localparam logic [1:0] EVT_IND = 2'd1;
    localparam logic [1:0] EVT_CONF = 2'd2;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_MISMATCH = 2'd1;
    localparam logic [1:0] ERR_ABORT = 2'd2;

    typedef enum logic [2:0] {
        OP_REQ = 3'd0,
        OP_DET = 3'd1,
        OP_ACK = 3'd2,
        OP_REJ = 3'd3,
        OP_REL = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_OUT  = 3'b010,
        PH_IN   = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        ST_UNKNOWN = 2'd0,
        ST_MASTER  = 2'd1,
        ST_SLAVE   = 2'd2,
        ST_INDET   = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]        operation;
        logic [TYPE_W-1:0] remote_type;
        logic [NUM_W-1:0]  remote_number;
        logic              ack_says_master;
        logic [NUM_W-1:0]  fresh_number;
    } in_t;

    typedef struct packed {
        logic [1:0]        send_kind;
        logic              send_master;
        logic [TYPE_W-1:0] send_type;
        logic [NUM_W-1:0]  send_number;
        logic [1:0]        event_kind;
        logic [1:0]        event_status;
        logic [1:0]        error_kind;
        logic              return_ok;
    } out_t;

    typedef struct packed {
        phase_t           phase;
        logic [CNT_W-1:0] retry_count;
        logic [NUM_W-1:0] local_number;
        status_t          decided;
    } state_t;

    typedef struct packed {
        logic [TYPE_W-1:0] term_type;
        logic [CNT_W-1:0]  retry_limit;
    } cfg_t;

endpackage

[src/master_slave_determination.sv]
// A beat accepted at the input is held in the input stage register, then moves to the result
// register, which drives out_valid and out_data until the beat is taken.
// Throughput: one beat per cycle; in_ready falls only while the input stage holds a beat
// and the result register is full and not being taken.
// Without cfg_we, state is updated as the input stage hands its beat to the result register.
// Reset (rst_n low, asynchronous) empties both stages, sets the phase idle, the retry count
// to zero, the local number to 1, the status unknown and the registers to their defaults.
module master_slave_determination (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  msd_pkg::in_t                        in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output msd_pkg::out_t                       out_data,
    input  logic                                cfg_we,
    input  logic [msd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [msd_pkg::NUM_W-1:0]           cfg_data
);
    import msd_pkg::*;

    logic   s1_valid_reg;
    in_t    s1_data_reg;
    logic   out_valid_reg;
    out_t   out_data_reg;
    state_t state_reg;
    state_t state_next;
    cfg_t   cfg_reg;
    out_t   step_res;
    logic   s1_fire;
    logic   in_fire;

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign in_fire  = in_valid && in_ready;

    msd_step u_step (
        .st      (state_reg),
        .cfg     (cfg_reg),
        .item    (s1_data_reg),
        .st_next (state_next),
        .res     (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_fire)
        begin
            out_data_reg <= step_res;
        end
    end

    // Write configuration only while idle, so it never meets a state update (unenforced).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= PH_IDLE;
            state_reg.retry_count  <= '0;
            state_reg.local_number <= INIT_NUMBER_RST;
            state_reg.decided      <= ST_UNKNOWN;
            cfg_reg.term_type      <= TERM_TYPE_RST;
            cfg_reg.retry_limit    <= RETRY_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_TERM_TYPE)
            begin
                cfg_reg.term_type <= cfg_data[TYPE_W-1:0];
            end
            else if (cfg_index == CFG_RETRY_LIMIT)
            begin
                cfg_reg.retry_limit <= cfg_data[CNT_W-1:0];
            end
            else if (cfg_index == CFG_INIT_NUMBER)
            begin
                state_reg.local_number <= cfg_data;
            end
        end
        else if (s1_fire)
        begin
            state_reg <= state_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    a_no_indet_status: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.decided != ST_INDET)
        else $error("decided status holds the indeterminate code");

    a_req_leaves_outgoing: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && step_res.send_kind == SEND_REQ) |=> state_reg.phase == PH_OUT)
        else $error("request sent but phase is not outgoing");

    a_abort_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && step_res.error_kind == ERR_ABORT) |=> state_reg.phase == PH_IDLE)
        else $error("release abort did not return to idle");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken while both stages are full and stalled");
`endif

endmodule

[src/msd_step.sv]
module msd_step (
    input  msd_pkg::state_t st,
    input  msd_pkg::cfg_t   cfg,
    input  msd_pkg::in_t    item,
    output msd_pkg::state_t st_next,
    output msd_pkg::out_t   res
);
    import msd_pkg::*;

    logic [NUM_W-1:0] diff;
    status_t          cmp_st;
    status_t          ack_st;
    logic             retry_ok;
    logic [CNT_W-1:0] cnt_inc;

    // Higher terminal type wins; on a tie the modular number difference decides.
    always_comb
    begin
        diff = item.remote_number - st.local_number;
        if (item.remote_type < cfg.term_type)
        begin
            cmp_st = ST_MASTER;
        end
        else if (item.remote_type > cfg.term_type)
        begin
            cmp_st = ST_SLAVE;
        end
        else if (diff == '0 || diff == HALF_RANGE)
        begin
            cmp_st = ST_INDET;
        end
        else if (diff < HALF_RANGE)
        begin
            cmp_st = ST_MASTER;
        end
        else
        begin
            cmp_st = ST_SLAVE;
        end
    end

    assign ack_st   = item.ack_says_master ? ST_MASTER : ST_SLAVE;
    assign retry_ok = (st.retry_count <= cfg.retry_limit);
    assign cnt_inc  = (st.retry_count == CNT_MAX) ? st.retry_count : st.retry_count + 1'b1;

    always_comb
    begin
        st_next = st;
        res     = '0;
        unique case (op_t'(item.operation))
            OP_REQ:
            begin
                res.return_ok = 1'b1;
                if (st.phase == PH_IDLE)
                begin
                    st_next.phase       = PH_OUT;
                    st_next.retry_count = CNT_W'(1);
                    res.send_kind       = SEND_REQ;
                    res.send_type       = cfg.term_type;
                    res.send_number     = st.local_number;
                end
            end
            OP_DET:
            begin
                if (st.phase != PH_IN)
                begin
                    if (cmp_st != ST_INDET)
                    begin
                        st_next.decided  = cmp_st;
                        st_next.phase    = PH_IN;
                        res.send_kind    = SEND_ACK;
                        res.send_master  = (cmp_st == ST_MASTER);
                        res.event_kind   = EVT_IND;
                        res.event_status = cmp_st;
                        res.return_ok    = 1'b1;
                    end
                    else if (st.phase == PH_IDLE)
                    begin
                        res.send_kind    = SEND_REJ;
                        res.event_kind   = EVT_IND;
                        res.event_status = st.decided;
                        res.return_ok    = 1'b1;
                    end
                    else if (retry_ok)
                    begin
                        st_next.local_number = item.fresh_number;
                        st_next.retry_count  = cnt_inc;
                        res.send_kind        = SEND_REQ;
                        res.send_type        = cfg.term_type;
                        res.send_number      = item.fresh_number;
                        res.event_kind       = EVT_IND;
                        res.event_status     = st.decided;
                        res.return_ok        = 1'b1;
                    end
                    else
                    begin
                        st_next.retry_count = '0;
                        st_next.phase       = PH_IDLE;
                    end
                end
            end
            OP_ACK:
            begin
                if (st.phase == PH_OUT)
                begin
                    st_next.decided  = ack_st;
                    st_next.phase    = PH_IDLE;
                    res.event_kind   = EVT_CONF;
                    res.event_status = ack_st;
                    res.return_ok    = 1'b1;
                end
                else if (st.phase == PH_IN)
                begin
                    if (ack_st != st.decided)
                    begin
                        res.error_kind = ERR_MISMATCH;
                    end
                    else
                    begin
                        st_next.phase    = PH_IDLE;
                        res.event_kind   = EVT_CONF;
                        res.event_status = st.decided;
                    end
                    res.return_ok = 1'b1;
                end
            end
            OP_REJ:
            begin
                if (st.phase == PH_OUT)
                begin
                    if (retry_ok)
                    begin
                        st_next.local_number = item.fresh_number;
                        st_next.retry_count  = cnt_inc;
                        res.send_kind        = SEND_REQ;
                        res.send_type        = cfg.term_type;
                        res.send_number      = item.fresh_number;
                        res.return_ok        = 1'b1;
                    end
                    else
                    begin
                        st_next.retry_count = '0;
                        st_next.phase       = PH_IDLE;
                    end
                end
                else if (st.phase == PH_IDLE)
                begin
                    res.return_ok = 1'b1;
                end
            end
            OP_REL:
            begin
                res.return_ok = 1'b1;
                if (st.phase != PH_IDLE)
                begin
                    st_next.phase  = PH_IDLE;
                    res.error_kind = ERR_ABORT;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

[tb/sv/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import msd_pkg::*;

    // Operation codes that the block must ignore.
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int NUM_SETTINGS      = 6;
    localparam int ITEMS_PER_SETTING = 220;
    localparam int QUIET_LIMIT       = 2000;
    localparam int SETTLE_CYCLES     = 4;
    localparam int DRAIN_CYCLES      = 8;

    // Tracks the protocol state of one side of the exchange and keeps the
    // replies it owes, oldest first.
    class decision_tracker;
        logic [TYPE_W-1:0] term_type;
        logic [CNT_W-1:0]  retry_limit;
        logic [NUM_W-1:0]  own_number;
        phase_t            phase;
        logic [CNT_W-1:0]  retries;
        status_t           decided;
        out_t              reply;
        out_t              pending_replies[$];
        int                errors;
        int                events_seen;
        int                replies_seen;
        int                indet_seen;
        int                giveups;
        int                conflicts;
        int                aborts;

        function new();
            term_type   = TERM_TYPE_RST;
            retry_limit = RETRY_LIMIT_RST;
            own_number  = INIT_NUMBER_RST;
            phase       = PH_IDLE;
            retries     = '0;
            decided     = ST_UNKNOWN;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [NUM_W-1:0] val);
            case (idx)
                CFG_TERM_TYPE:   term_type = val[TYPE_W-1:0];
                CFG_RETRY_LIMIT: retry_limit = val[CNT_W-1:0];
                CFG_INIT_NUMBER: own_number = val;
                default: ;
            endcase
        endfunction

        // Higher terminal type wins; on a tie the modular number difference decides.
        function status_t compare_numbers(logic [TYPE_W-1:0] rtype, logic [NUM_W-1:0] rnum);
            logic [NUM_W-1:0] diff;
            if (rtype < term_type) return ST_MASTER;
            if (rtype > term_type) return ST_SLAVE;
            diff = rnum - own_number;
            if (diff == '0 || diff == HALF_RANGE) return ST_INDET;
            return (diff < HALF_RANGE) ? ST_MASTER : ST_SLAVE;
        endfunction

        function void send_request();
            reply.send_kind   = SEND_REQ;
            reply.send_type   = term_type;
            reply.send_number = own_number;
        endfunction

        function void raise(logic [1:0] evt);
            reply.event_kind   = evt;
            reply.event_status = decided;
        endfunction

        // The limit check comes before the increment, so the count has to
        // exceed the limit before the exchange is given up.
        function bit try_again(logic [NUM_W-1:0] fresh);
            if (retries > retry_limit) begin
                retries = '0;
                phase = PH_IDLE;
                giveups++;
                return 1'b0;
            end
            own_number = fresh;
            if (retries != CNT_MAX) retries++;
            send_request();
            return 1'b1;
        endfunction

        function void take_event(in_t ev);
            status_t ns;
            reply = '0;
            events_seen++;
            case (ev.operation)
                OP_REQ:
                begin
                    reply.return_ok = 1'b1;
                    if (phase == PH_IDLE) begin
                        phase = PH_OUT;
                        retries = CNT_W'(1);
                        send_request();
                    end
                end
                OP_DET:
                begin
                    if (phase != PH_IN) begin
                        ns = compare_numbers(ev.remote_type, ev.remote_number);
                        if (ns != ST_INDET) begin
                            decided = ns;
                            phase = PH_IN;
                            reply.send_kind = SEND_ACK;
                            reply.send_master = (ns == ST_MASTER);
                            raise(EVT_IND);
                            reply.return_ok = 1'b1;
                        end else begin
                            indet_seen++;
                            if (phase == PH_IDLE) begin
                                reply.send_kind = SEND_REJ;
                                raise(EVT_IND);
                                reply.return_ok = 1'b1;
                            end else if (try_again(ev.fresh_number)) begin
                                raise(EVT_IND);
                                reply.return_ok = 1'b1;
                            end
                        end
                    end
                end
                OP_ACK:
                begin
                    ns = ev.ack_says_master ? ST_MASTER : ST_SLAVE;
                    if (phase == PH_OUT) begin
                        decided = ns;
                        raise(EVT_CONF);
                        phase = PH_IDLE;
                        reply.return_ok = 1'b1;
                    end else if (phase == PH_IN) begin
                        if (ns != decided) begin
                            reply.error_kind = ERR_MISMATCH;
                            conflicts++;
                        end else begin
                            raise(EVT_CONF);
                            phase = PH_IDLE;
                        end
                        reply.return_ok = 1'b1;
                    end
                end
                OP_REJ:
                begin
                    if (phase == PH_OUT) reply.return_ok = try_again(ev.fresh_number);
                    else if (phase == PH_IDLE) reply.return_ok = 1'b1;
                end
                OP_REL:
                begin
                    reply.return_ok = 1'b1;
                    if (phase != PH_IDLE) begin
                        phase = PH_IDLE;
                        reply.error_kind = ERR_ABORT;
                        aborts++;
                    end
                end
                default: ;
            endcase
            pending_replies.push_back(reply);
        endfunction

        function void flag(string what, out_t want, out_t got);
            errors++;
            if (errors <= 10) begin
                $display("ERROR reply %0d: %s", replies_seen, what);
                $display("  expected send=%0d/%0d/%02h/%06h event=%0d/%0d error=%0d ok=%0d",
                         want.send_kind, want.send_master, want.send_type, want.send_number,
                         want.event_kind, want.event_status, want.error_kind, want.return_ok);
                $display("  actual   send=%0d/%0d/%02h/%06h event=%0d/%0d error=%0d ok=%0d",
                         got.send_kind, got.send_master, got.send_type, got.send_number,
                         got.event_kind, got.event_status, got.error_kind, got.return_ok);
            end
        endfunction

        function void match_reply(out_t got);
            out_t  want;
            string diffs;
            replies_seen++;
            if (pending_replies.size() == 0) begin
                flag("reply arrived with nothing outstanding", '0, got);
                return;
            end
            want = pending_replies.pop_front();
            diffs = "";
            if (got.send_kind !== want.send_kind) diffs = {diffs, " send_kind"};
            if (got.send_master !== want.send_master) diffs = {diffs, " send_master"};
            if (got.send_type !== want.send_type) diffs = {diffs, " send_type"};
            if (got.send_number !== want.send_number) diffs = {diffs, " send_number"};
            if (got.event_kind !== want.event_kind) diffs = {diffs, " event_kind"};
            if (got.event_status !== want.event_status) diffs = {diffs, " event_status"};
            if (got.error_kind !== want.error_kind) diffs = {diffs, " error_kind"};
            if (got.return_ok !== want.return_ok) diffs = {diffs, " return_ok"};
            if (diffs != "") flag({"wrong", diffs}, want, got);
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_t                  in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_t                 out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [NUM_W-1:0]     cfg_data = '0;

    decision_tracker tracker = new();
    bit              in_busy = 1'b1;
    bit              out_busy = 1'b1;
    int              quiet_cycles = 0;

    master_slave_determination u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5ns clk = ~clk;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: a random stall before each beat, in bursts with and without stalls.
    initial
    begin
        int stall;
        forever begin
            if ($urandom_range(0, 39) == 0) out_busy = !out_busy;
            stall = out_busy ? $urandom_range(0, 12) : 0;
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            tracker.match_reply(out_data);
        end
    end

    task automatic push_event(in_t ev);
        int gap;
        if ($urandom_range(0, 39) == 0) in_busy = !in_busy;
        gap = in_busy ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= ev;
        do @(posedge clk); while (!in_ready);
        tracker.take_event(ev);
    endtask

    task automatic send_op(logic [2:0] op, logic [TYPE_W-1:0] rtype,
                           logic [NUM_W-1:0] rnum, logic says_master,
                           logic [NUM_W-1:0] fresh);
        in_t ev;
        ev.operation = op;
        ev.remote_type = rtype;
        ev.remote_number = rnum;
        ev.ack_says_master = says_master;
        ev.fresh_number = fresh;
        push_event(ev);
    endtask

    task automatic stop_input();
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (tracker.pending_replies.size() != 0) @(posedge clk);
    endtask

    task automatic write_settings(logic [TYPE_W-1:0] ttype, logic [CNT_W-1:0] limit,
                                  logic [NUM_W-1:0] number);
        logic [NUM_W-1:0] vals[3];
        logic [CFG_IDX_W-1:0] idxs[3];
        vals = '{NUM_W'(ttype), NUM_W'(limit), number};
        idxs = '{CFG_TERM_TYPE, CFG_RETRY_LIMIT, CFG_INIT_NUMBER};
        for (int i = 0; i < 3; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= idxs[i];
            cfg_data <= vals[i];
            @(posedge clk);
            tracker.set_register(idxs[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // Mostly events that fit the current phase, with some out of place and a
    // few unused codes. Determinations often tie on type and sometimes on the
    // number as well, so the indeterminate and retry paths are reached.
    function automatic in_t draw_event();
        in_t ev;
        int  roll;
        ev.remote_type = TYPE_W'($urandom_range(0, 255));
        ev.remote_number = NUM_W'($urandom_range(0, 24'hffffff));
        ev.ack_says_master = 1'($urandom_range(0, 1));
        ev.fresh_number = ($urandom_range(0, 31) == 0) ? '0 :
                          NUM_W'($urandom_range(0, 24'hffffff));
        roll = $urandom_range(0, 99);
        case (tracker.phase)
            PH_IDLE:
                ev.operation = (roll < 35) ? OP_REQ : (roll < 75) ? OP_DET :
                               (roll < 82) ? OP_ACK : (roll < 89) ? OP_REJ :
                               (roll < 96) ? OP_REL :
                               3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            PH_OUT:
                ev.operation = (roll < 30) ? OP_REJ : (roll < 55) ? OP_DET :
                               (roll < 78) ? OP_ACK : (roll < 83) ? OP_REQ :
                               (roll < 96) ? OP_REL :
                               3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            default:
            begin
                ev.operation = (roll < 55) ? OP_ACK : (roll < 65) ? OP_DET :
                               (roll < 75) ? OP_REJ : (roll < 85) ? OP_REL :
                               (roll < 96) ? OP_REQ :
                               3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                if ($urandom_range(0, 4) != 0)
                    ev.ack_says_master = (tracker.decided == ST_MASTER);
            end
        endcase
        if (ev.operation == OP_DET && $urandom_range(0, 1) == 1) begin
            ev.remote_type = tracker.term_type;
            roll = $urandom_range(0, 9);
            if (roll < 2) ev.remote_number = tracker.own_number;
            else if (roll < 4) ev.remote_number = tracker.own_number + HALF_RANGE;
        end
        return ev;
    endfunction

    initial
    begin
        logic [TYPE_W-1:0] ttype;
        logic [CNT_W-1:0]  limit;
        logic [NUM_W-1:0]  number;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: type 0, limit 100, own number 1.
        send_op(OP_ACK, 8'h00, 24'h000000, 1'b1, 24'h000005);
        send_op(OP_REJ, 8'h00, 24'h000000, 1'b0, 24'h000005);
        send_op(OP_REL, 8'h00, 24'h000000, 1'b0, 24'h000005);
        send_op(OP_DET, 8'h00, 24'h000001, 1'b0, 24'h000005);
        send_op(OP_DET, 8'h00, 24'h800001, 1'b0, 24'h000005);
        send_op(OP_DET, 8'h00, 24'h800002, 1'b0, 24'h000005);
        send_op(OP_DET, 8'h00, 24'h000003, 1'b0, 24'h000005);
        send_op(OP_REJ, 8'h00, 24'h000000, 1'b0, 24'h000005);
        send_op(OP_ACK, 8'h00, 24'h000000, 1'b1, 24'h000005);
        send_op(OP_ACK, 8'h00, 24'h000000, 1'b0, 24'h000005);
        send_op(OP_REQ, 8'h00, 24'h000000, 1'b0, 24'h000005);
        send_op(OP_REQ, 8'h00, 24'h000000, 1'b0, 24'h000005);
        // A retry takes the fresh number as given, zero included.
        send_op(OP_REJ, 8'h00, 24'h000000, 1'b0, 24'h000000);
        send_op(OP_DET, 8'h00, 24'h000000, 1'b0, 24'hffffff);
        send_op(OP_DET, 8'h00, 24'h000000, 1'b0, 24'h000005);
        send_op(OP_ACK, 8'h00, 24'h000000, 1'b1, 24'h000005);
        send_op(OP_REQ, 8'h00, 24'h000000, 1'b0, 24'h000005);
        send_op(OP_ACK, 8'h00, 24'h000000, 1'b0, 24'h000005);
        send_op(OP_REQ, 8'h00, 24'h000000, 1'b0, 24'h000005);
        send_op(OP_REL, 8'h00, 24'h000000, 1'b0, 24'h000005);
        send_op(OP_DET, 8'hff, 24'hffffff, 1'b1, 24'hffffff);
        send_op(OP_REL, 8'hff, 24'hffffff, 1'b1, 24'hffffff);
        send_op(OP_SPARE_LO, 8'hff, 24'hffffff, 1'b1, 24'hffffff);
        send_op(OP_SPARE_LO + 3'd1, 8'hff, 24'hffffff, 1'b1, 24'hffffff);
        send_op(OP_SPARE_HI, 8'hff, 24'hffffff, 1'b1, 24'hffffff);

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            stop_input();
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
            case (s)
                0:
                begin
                    ttype = 8'h00; limit = 8'd1; number = 24'h000001;
                end
                1:
                begin
                    ttype = 8'hff; limit = 8'd254; number = 24'hffffff;
                end
                2:
                begin
                    ttype = 8'h80; limit = 8'd3; number = 24'h800000;
                end
                3:
                begin
                    ttype = TYPE_W'($urandom_range(0, 255));
                    limit = CNT_W'($urandom_range(1, 8));
                    number = NUM_W'($urandom_range(1, 24'hffffff));
                end
                4:
                begin
                    ttype = TYPE_W'($urandom_range(0, 255));
                    limit = CNT_W'($urandom_range(1, 254));
                    number = NUM_W'($urandom_range(1, 24'hffffff));
                end
                default:
                begin
                    ttype = 8'h01; limit = 8'd2; number = 24'h7fffff;
                end
            endcase
            write_settings(ttype, limit, number);
            if (limit == 8'd254) begin
                // Reject every attempt until the highest limit is used up,
                // then once more while idle.
                send_op(OP_REL, 8'h00, 24'h000000, 1'b0, 24'h000001);
                send_op(OP_REQ, 8'h00, 24'h000000, 1'b0, 24'h000001);
                repeat (256)
                    send_op(OP_REJ, 8'h00, 24'h000000, 1'b0,
                            NUM_W'($urandom_range(0, 24'hffffff)));
            end
            repeat (ITEMS_PER_SETTING) push_event(draw_event());
        end

        stop_input();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d events and %0d replies across %0d register settings.",
                 tracker.events_seen, tracker.replies_seen, NUM_SETTINGS + 1);
        $display("Saw %0d indeterminate numbers, %0d retry give-ups, %0d ack conflicts, %0d aborts.",
                 tracker.indet_seen, tracker.giveups, tracker.conflicts, tracker.aborts);
        if (tracker.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d reply errors", tracker.errors);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
src/msd_pkg.sv
src/msd_step.sv
src/master_slave_determination.sv
tb/sv/tb_top.sv
